>>> rtl/tfd_pkg.sv
// Package: types, codes and decode table for the typed field to double unit.
package tfd_pkg;

  localparam logic [63:0] QNAN_BITS = 64'h7FF8_0000_0000_0000;

  typedef enum logic [3:0] {
    KIND_UNKNOWN = 4'd0,
    KIND_INT8    = 4'd1,
    KIND_UINT8   = 4'd2,
    KIND_INT16   = 4'd3,
    KIND_UINT16  = 4'd4,
    KIND_INT32   = 4'd5,
    KIND_UINT32  = 4'd6,
    KIND_INT64   = 4'd7,
    KIND_UINT64  = 4'd8,
    KIND_FLOAT   = 4'd9,
    KIND_DOUBLE  = 4'd10,
    KIND_CHAR    = 4'd11,
    KIND_STR4    = 4'd12,
    KIND_STR16   = 4'd13,
    KIND_STR64   = 4'd14,
    KIND_STR256  = 4'd15
  } kind_e;

  localparam logic [7:0] CODE_I8   = 8'h62; // b
  localparam logic [7:0] CODE_U8   = 8'h42; // B
  localparam logic [7:0] CODE_I16  = 8'h68; // h
  localparam logic [7:0] CODE_U16  = 8'h48; // H
  localparam logic [7:0] CODE_I32  = 8'h69; // i
  localparam logic [7:0] CODE_U32  = 8'h49; // I
  localparam logic [7:0] CODE_I64  = 8'h71; // q
  localparam logic [7:0] CODE_U64  = 8'h51; // Q
  localparam logic [7:0] CODE_F32  = 8'h66; // f
  localparam logic [7:0] CODE_F64  = 8'h64; // d
  localparam logic [7:0] CODE_CHR  = 8'h63; // c
  localparam logic [7:0] CODE_S4   = 8'h6E; // n
  localparam logic [7:0] CODE_S16  = 8'h4E; // N
  localparam logic [7:0] CODE_S64  = 8'h5A; // Z
  localparam logic [7:0] CODE_S256 = 8'h54; // T

  typedef struct packed {
    logic [7:0]  format_code;
    logic [63:0] raw_word;
    logic        complete;
  } tfd_in_t;

  typedef struct packed {
    logic [63:0] value_bits;
    logic [8:0]  element_bytes;
    logic [3:0]  value_kind;
  } tfd_out_t;

  // Stage 1 -> stage 2: magnitude and side info.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [8:0]  bytes;
    logic        complete;
    logic        neg;
    logic [63:0] mag;
    logic [63:0] raw;
  } tfd_s1_t;

  // Stage 2 -> stage 3: normalized magnitude.
  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [8:0]  bytes;
    logic        complete;
    logic        neg;
    logic        zero;
    logic [5:0]  msb;
    logic [63:0] norm;
    logic [63:0] raw;
  } tfd_s2_t;

  function automatic kind_e decode_kind(input logic [7:0] code);
    kind_e k;
    k = KIND_UNKNOWN;
    case (code)
      CODE_I8:   k = KIND_INT8;
      CODE_U8:   k = KIND_UINT8;
      CODE_I16:  k = KIND_INT16;
      CODE_U16:  k = KIND_UINT16;
      CODE_I32:  k = KIND_INT32;
      CODE_U32:  k = KIND_UINT32;
      CODE_I64:  k = KIND_INT64;
      CODE_U64:  k = KIND_UINT64;
      CODE_F32:  k = KIND_FLOAT;
      CODE_F64:  k = KIND_DOUBLE;
      CODE_CHR:  k = KIND_CHAR;
      CODE_S4:   k = KIND_STR4;
      CODE_S16:  k = KIND_STR16;
      CODE_S64:  k = KIND_STR64;
      CODE_S256: k = KIND_STR256;
      default:   k = KIND_UNKNOWN;
    endcase
    return k;
  endfunction

  function automatic logic [8:0] kind_bytes(input kind_e k);
    logic [8:0] b;
    b = 9'd0;
    case (k)
      KIND_INT8, KIND_UINT8, KIND_CHAR:            b = 9'd1;
      KIND_INT16, KIND_UINT16:                     b = 9'd2;
      KIND_INT32, KIND_UINT32, KIND_FLOAT, KIND_STR4: b = 9'd4;
      KIND_INT64, KIND_UINT64, KIND_DOUBLE:        b = 9'd8;
      KIND_STR16:                                  b = 9'd16;
      KIND_STR64:                                  b = 9'd64;
      KIND_STR256:                                 b = 9'd256;
      default:                                     b = 9'd0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/typed_field_to_double_unit.sv
// Top level: typed field to binary64 converter, three-stage pipeline.
//
// Usage: drive item_i and raise start; the transaction is taken at a rising
// edge with start high and busy low. busy is tied low, so a new transaction
// may enter every cycle.
// Output: done_o is high for one cycle only, once the transaction has passed
// the stage 1, stage 2 and output registers; result_o is valid then.
// Throughput: one transaction per cycle; stages are decode and extract,
// leading-one search and shift, then round and assemble.
// Reset: asynchronous, active low; clears the stage registers and the valid
// bits so no stale result is strobed. The output payload is not reset.
// The receiver cannot stall: each result must be captured in its cycle.
module typed_field_to_double_unit
  import tfd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  tfd_in_t  item_i,
  output logic     done_o,
  output tfd_out_t result_o
);

  tfd_s1_t s1;
  tfd_s2_t s2;
  logic    accept;

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  tfd_extract u_extract (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(accept),
    .item_i (item_i),
    .s1_o   (s1)
  );

  tfd_normalize u_normalize (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .s1_i  (s1),
    .s2_o  (s2)
  );

  tfd_pack u_pack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .s2_i    (s2),
    .valid_o (done_o),
    .result_o(result_o)
  );

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##3 done_o)
    else $error("result missing three cycles after a transaction");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 3))
    else $error("result without a transaction");

  a_unknown_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && result_o.value_kind == KIND_UNKNOWN |-> result_o.element_bytes == 9'd0)
    else $error("unknown kind with nonzero byte width");

endmodule

>>> rtl/tfd_extract.sv
// Stage 1: decode the format code and extract sign and magnitude.
module tfd_extract
  import tfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  tfd_in_t item_i,
  output tfd_s1_t s1_o
);

  kind_e       kind;
  logic        neg;
  logic [63:0] mag;
  logic [63:0] r;
  tfd_s1_t     s1_q;

  assign r    = item_i.raw_word;
  assign kind = decode_kind(item_i.format_code);

  always_comb begin
    neg = 1'b0;
    mag = 64'd0;
    case (kind)
      KIND_INT8: begin
        neg = r[7];
        mag = {56'd0, r[7] ? 8'(-r[7:0]) : r[7:0]};
      end
      KIND_UINT8:  mag = {56'd0, r[7:0]};
      KIND_INT16: begin
        neg = r[15];
        mag = {48'd0, r[15] ? 16'(-r[15:0]) : r[15:0]};
      end
      KIND_UINT16: mag = {48'd0, r[15:0]};
      KIND_INT32: begin
        neg = r[31];
        mag = {32'd0, r[31] ? 32'(-r[31:0]) : r[31:0]};
      end
      KIND_UINT32: mag = {32'd0, r[31:0]};
      KIND_INT64: begin
        neg = r[63];
        mag = r[63] ? 64'(-r) : r;
      end
      KIND_UINT64: mag = r;
      KIND_FLOAT:  mag = {41'd0, r[22:0]};
      default: begin
        neg = 1'b0;
        mag = 64'd0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else begin
      s1_q.valid    <= valid_i;
      s1_q.kind     <= kind;
      s1_q.bytes    <= kind_bytes(kind);
      s1_q.complete <= item_i.complete;
      s1_q.neg      <= neg;
      s1_q.mag      <= mag;
      s1_q.raw      <= r;
    end
  end

  assign s1_o = s1_q;

endmodule

>>> rtl/tfd_normalize.sv
// Stage 2: find the leading one and left-align the magnitude.
module tfd_normalize
  import tfd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  tfd_s1_t s1_i,
  output tfd_s2_t s2_o
);

  logic [5:0]  msb;
  logic [63:0] norm;
  tfd_s2_t     s2_q;

  always_comb begin
    msb = 6'd0;
    for (int k = 0; k < 64; k++) begin
      if (s1_i.mag[k]) begin
        msb = 6'(k);
      end
    end
  end

  assign norm = s1_i.mag << (6'd63 - msb);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
    end else begin
      s2_q.valid    <= s1_i.valid;
      s2_q.kind     <= s1_i.kind;
      s2_q.bytes    <= s1_i.bytes;
      s2_q.complete <= s1_i.complete;
      s2_q.neg      <= s1_i.neg;
      s2_q.zero     <= (s1_i.mag == 64'd0);
      s2_q.msb      <= msb;
      s2_q.norm     <= norm;
      s2_q.raw      <= s1_i.raw;
    end
  end

  assign s2_o = s2_q;

endmodule

>>> rtl/tfd_pack.sv
// Stage 3: round, assemble the binary64 pattern and register the result.
module tfd_pack
  import tfd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tfd_s2_t  s2_i,
  output logic     valid_o,
  output tfd_out_t result_o
);

  logic [51:0] mant;
  logic        rnd;
  logic        sticky;
  logic [62:0] mag_bits;
  logic [63:0] int_bits;
  logic [63:0] flt_bits;
  logic [63:0] val;
  logic [7:0]  fexp;
  logic        fsign;
  logic [10:0] sub_exp;
  logic        valid_q;
  tfd_out_t    result_q;

  assign mant     = s2_i.norm[62:11];
  assign rnd      = s2_i.norm[10];
  assign sticky   = |s2_i.norm[9:0];
  assign mag_bits = {11'(11'd1023 + 11'(s2_i.msb)), mant}
                  + 63'(rnd & (sticky | mant[0]));
  assign int_bits = s2_i.zero ? {s2_i.neg, 63'd0} : {s2_i.neg, mag_bits};

  assign fsign   = s2_i.raw[31];
  assign fexp    = s2_i.raw[30:23];
  assign sub_exp = 11'(11'd874 + 11'(s2_i.msb));

  always_comb begin
    if (fexp == 8'hFF) begin
      if (s2_i.raw[22:0] == 23'd0) begin
        flt_bits = {fsign, 11'h7FF, 52'd0};
      end else begin
        flt_bits = {fsign, 11'h7FF, 1'b1, s2_i.raw[21:0], 29'd0};
      end
    end else if (fexp == 8'd0) begin
      flt_bits = s2_i.zero ? {fsign, 63'd0} : {fsign, sub_exp, mant};
    end else begin
      flt_bits = {fsign, 11'(11'(fexp) + 11'd896), s2_i.raw[22:0], 29'd0};
    end
  end

  always_comb begin
    val = QNAN_BITS;
    if (s2_i.complete) begin
      case (s2_i.kind)
        KIND_INT8, KIND_UINT8, KIND_INT16, KIND_UINT16,
        KIND_INT32, KIND_UINT32, KIND_INT64, KIND_UINT64: val = int_bits;
        KIND_FLOAT:  val = flt_bits;
        KIND_DOUBLE: val = s2_i.raw;
        default:     val = QNAN_BITS;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= s2_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q.value_bits    <= val;
    result_q.element_bytes <= s2_i.bytes;
    result_q.value_kind    <= s2_i.kind;
  end

  assign valid_o  = valid_q;
  assign result_o = result_q;

endmodule

>>> tb/tfd_checker.sv
// Checker: watches the transaction and result channels, predicts and compares results.
`timescale 1ns / 1ps
module tfd_checker
  import tfd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     busy,
  input  tfd_in_t  item_i,
  input  logic     done_i,
  input  tfd_out_t result_i,
  output int       fail_count_o,
  output int       pending_count_o,
  output int       result_count_o
);

  localparam logic [63:0] MANT_MASK = 64'h000F_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGN_MASK = 64'h8000_0000_0000_0000;
  localparam int EXP_DEPTH = 16;

  tfd_out_t exp_mem[EXP_DEPTH];
  int       wr_q;
  int       rd_q;

  function automatic int top_bit(input logic [63:0] v);
    int p;
    p = 0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) begin
        p = k;
      end
    end
    return p;
  endfunction

  function automatic logic [63:0] mag_to_f64(input logic [63:0] v, input logic neg);
    logic [63:0] bits;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int p;
    int sh;
    if (v == 64'd0) begin
      return neg ? SIGN_MASK : 64'd0;
    end
    p = top_bit(v);
    if (p <= 52) begin
      bits = (64'(1023 + p) << 52) | ((v << (52 - p)) & MANT_MASK);
    end else begin
      sh = p - 52;
      mant = v >> sh;
      rem = v & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      bits = (64'(1023 + p) << 52) | (mant & MANT_MASK);
      if (rem > half || (rem == half && mant[0])) begin
        bits = bits + 64'd1;
      end
    end
    return neg ? (bits | SIGN_MASK) : bits;
  endfunction

  function automatic logic [63:0] int_to_f64(input logic [63:0] raw, input int width,
                                             input logic is_signed);
    logic [63:0] mask;
    logic [63:0] v;
    mask = (width == 64) ? '1 : ((64'd1 << width) - 64'd1);
    v = raw & mask;
    if (is_signed && v[width-1]) begin
      return mag_to_f64((64'd0 - v) & mask, 1'b1);
    end
    return mag_to_f64(v, 1'b0);
  endfunction

  function automatic logic [63:0] f32_to_f64(input logic [31:0] f);
    logic [63:0] s;
    logic [7:0] e;
    logic [63:0] m;
    int p;
    s = {f[31], 63'd0};
    e = f[30:23];
    m = {41'd0, f[22:0]};
    if (e == 8'hFF) begin
      if (m == 0) begin
        return s | 64'h7FF0_0000_0000_0000;
      end
      return s | 64'h7FF0_0000_0000_0000 | (m << 29) | (64'd1 << 51);
    end
    if (e == 8'h00) begin
      if (m == 0) begin
        return s;
      end
      p = top_bit(m);
      return s | (64'(1023 + p - 149) << 52) | ((m << (52 - p)) & MANT_MASK);
    end
    return s | (64'(e + 896) << 52) | (m << 29);
  endfunction

  function automatic tfd_out_t convert_field(input tfd_in_t it);
    tfd_out_t r;
    kind_e k;
    logic [8:0] nb;
    k = KIND_UNKNOWN;
    nb = 9'd0;
    case (it.format_code)
      CODE_I8:   begin k = KIND_INT8;    nb = 9'd1;   end
      CODE_U8:   begin k = KIND_UINT8;   nb = 9'd1;   end
      CODE_I16:  begin k = KIND_INT16;   nb = 9'd2;   end
      CODE_U16:  begin k = KIND_UINT16;  nb = 9'd2;   end
      CODE_I32:  begin k = KIND_INT32;   nb = 9'd4;   end
      CODE_U32:  begin k = KIND_UINT32;  nb = 9'd4;   end
      CODE_I64:  begin k = KIND_INT64;   nb = 9'd8;   end
      CODE_U64:  begin k = KIND_UINT64;  nb = 9'd8;   end
      CODE_F32:  begin k = KIND_FLOAT;   nb = 9'd4;   end
      CODE_F64:  begin k = KIND_DOUBLE;  nb = 9'd8;   end
      CODE_CHR:  begin k = KIND_CHAR;    nb = 9'd1;   end
      CODE_S4:   begin k = KIND_STR4;    nb = 9'd4;   end
      CODE_S16:  begin k = KIND_STR16;   nb = 9'd16;  end
      CODE_S64:  begin k = KIND_STR64;   nb = 9'd64;  end
      CODE_S256: begin k = KIND_STR256;  nb = 9'd256; end
      default:   begin k = KIND_UNKNOWN; nb = 9'd0;   end
    endcase
    r.value_bits = QNAN_BITS;
    if (it.complete) begin
      case (k)
        KIND_INT8:   r.value_bits = int_to_f64(it.raw_word, 8, 1'b1);
        KIND_UINT8:  r.value_bits = int_to_f64(it.raw_word, 8, 1'b0);
        KIND_INT16:  r.value_bits = int_to_f64(it.raw_word, 16, 1'b1);
        KIND_UINT16: r.value_bits = int_to_f64(it.raw_word, 16, 1'b0);
        KIND_INT32:  r.value_bits = int_to_f64(it.raw_word, 32, 1'b1);
        KIND_UINT32: r.value_bits = int_to_f64(it.raw_word, 32, 1'b0);
        KIND_INT64:  r.value_bits = int_to_f64(it.raw_word, 64, 1'b1);
        KIND_UINT64: r.value_bits = int_to_f64(it.raw_word, 64, 1'b0);
        KIND_FLOAT:  r.value_bits = f32_to_f64(it.raw_word[31:0]);
        KIND_DOUBLE: r.value_bits = it.raw_word;
        default:     r.value_bits = QNAN_BITS;
      endcase
    end
    r.element_bytes = nb;
    r.value_kind = k;
    return r;
  endfunction

  assign pending_count_o = wr_q - rd_q;

  always @(posedge clk_i or negedge rst_ni) begin
    tfd_out_t exp_r;
    int errs;
    if (!rst_ni) begin
      wr_q <= 0;
      rd_q <= 0;
      fail_count_o <= 0;
      result_count_o <= 0;
    end else begin
      errs = 0;
      if (done_i) begin
        result_count_o <= result_count_o + 1;
        if (wr_q == rd_q) begin
          $error("result with no transaction outstanding: %h", result_i);
          errs++;
        end else begin
          exp_r = exp_mem[rd_q % EXP_DEPTH];
          rd_q <= rd_q + 1;
          if (exp_r.value_bits !== result_i.value_bits) begin
            $error("value_bits: expected %h actual %h", exp_r.value_bits,
                   result_i.value_bits);
            errs++;
          end
          if (exp_r.element_bytes !== result_i.element_bytes) begin
            $error("element_bytes: expected %0d actual %0d", exp_r.element_bytes,
                   result_i.element_bytes);
            errs++;
          end
          if (exp_r.value_kind !== result_i.value_kind) begin
            $error("value_kind: expected %0d actual %0d", exp_r.value_kind,
                   result_i.value_kind);
            errs++;
          end
        end
      end
      if (start && !busy) begin
        exp_mem[wr_q % EXP_DEPTH] <= convert_field(item_i);
        wr_q <= wr_q + 1;
      end
      fail_count_o <= fail_count_o + errs;
    end
  end

endmodule

>>> tb/tb_typed_field_to_double_unit.sv
// Testbench top: drives conversion transactions into the unit and reports the verdict.
`timescale 1ns / 1ps
module tb_typed_field_to_double_unit;
  import tfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 450;

  logic     clk_i;
  logic     rst_ni;
  logic     start;
  logic     busy;
  tfd_in_t  item_i;
  logic     done;
  tfd_out_t result_o;
  int       fail_count;
  int       pending_count;
  int       result_count;
  int       sent_count;
  int       idle_cycles;

  logic [7:0] code_list[15] = '{CODE_I8, CODE_U8, CODE_I16, CODE_U16, CODE_I32,
                                CODE_U32, CODE_I64, CODE_U64, CODE_F32, CODE_F64,
                                CODE_CHR, CODE_S4, CODE_S16, CODE_S64, CODE_S256};

  typed_field_to_double_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .done_o  (done),
    .result_o(result_o)
  );

  tfd_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .done_i         (done),
    .result_i       (result_o),
    .fail_count_o   (fail_count),
    .pending_count_o(pending_count),
    .result_count_o (result_count)
  );

  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_typed_field_to_double_unit: done, errors");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic [63:0] shaped_word();
    logic [63:0] w;
    w = rand_word();
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = w >> $urandom_range(0, 63);
      3: w = {w[63:32], 1'b0, 8'h00, w[22:0]};
      4: w = {w[63:32], w[31], 8'hFF, w[22:0]};
      5: w = {w[63:11], 11'h400};
      6: w = {w[63:53], 1'b1, 52'd0} | (64'd1 << $urandom_range(0, 63));
      default: ;
    endcase
    return w;
  endfunction

  task automatic send_field(input logic [7:0] code, input logic [63:0] word,
                            input logic cmpl);
    start <= 1'b1;
    item_i <= '{format_code: code, raw_word: word, complete: cmpl};
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sent_count++;
  endtask

  task automatic random_gap();
    int n;
    n = 0;
    if ($urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 3);
    end
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [7:0] code;
    sent_count = 0;
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (code_list[k]) begin
      send_field(code_list[k], 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    end
    send_field(CODE_I64, 64'h8000_0000_0000_0000, 1'b1);
    send_field(CODE_U64, 64'h0020_0000_0000_0003, 1'b1);
    send_field(CODE_F32, 64'h0000_0000_7F80_0001, 1'b1);
    send_field(CODE_F32, 64'h0000_0000_8000_0001, 1'b1);
    send_field(CODE_F64, 64'h7FF0_0000_0000_0001, 1'b1);
    send_field(CODE_I32, 64'h0, 1'b0);
    send_field(8'h00, 64'h1234, 1'b1);
    send_field(8'hFF, 64'h0, 1'b1);
    send_field(CODE_U8, 64'hFFFF_FFFF_FFFF_FF00, 1'b1);
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 19) == 0) begin
        code = 8'($urandom_range(0, 255));
      end else begin
        code = code_list[$urandom_range(0, 14)];
      end
      send_field(code, shaped_word(), $urandom_range(0, 9) != 0);
      if (n == RANDOM_ITEMS / 2) begin
        start <= 1'b0;
        while (pending_count != 0) @(posedge clk_i);
      end else if (n > 60) begin
        random_gap();
      end
    end
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("Sent %0d conversion transactions over all format codes, %0d results checked.",
             sent_count, result_count);
    if (fail_count == 0) begin
      $display("tb_typed_field_to_double_unit: done, clean");
    end else begin
      $display("tb_typed_field_to_double_unit: done, errors");
    end
    $finish;
  end

endmodule
